// ===== src/gdoy_pkg.sv =====
// Shared types, constants and the month-length table of the day-of-year converter.
`default_nettype none

package gdoy_pkg;

  // Operation codes carried in the func field of a request.
  localparam logic FuncDateToYday = 1'b0;
  localparam logic FuncYdayToDate = 1'b1;

  // Status codes of a result.
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  localparam logic [8:0] DaysCommon   = 9'd365;
  localparam logic [8:0] DaysLeap     = 9'd366;
  localparam logic [3:0] MonthsPerYr  = 4'd12;
  localparam logic [3:0] LastMonthIdx = 4'd11;

  // floor(y / 25) == (y * 5243) >> 17 holds for every y below 43690, which
  // covers all non-negative 16-bit years.
  localparam int unsigned  YearBits    = 15;
  localparam int unsigned  Recip25Bits = 13;
  localparam int unsigned  ProdBits    = YearBits + Recip25Bits;
  localparam int unsigned  Recip25Sh   = 17;
  localparam int unsigned  QuoBits     = ProdBits - Recip25Sh;
  localparam logic [Recip25Bits-1:0] Recip25 = 13'd5243;
  localparam logic [YearBits-1:0]    Div25   = 15'd25;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic divide;   // register the quotient of year by 25
    logic check;    // settle leap year, validity and start the month walk
    logic step;     // advance the month walk by one month
    logic emit;     // load the result register
  } gdoy_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic bad;   // request is invalid (valid during the check command)
    logic more;  // the month walk needs another step
  } gdoy_sts_t;

  // Length of month idx (0 = January); zero for indexes past December.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] idx);
    logic [4:0] len;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/gdoy_if.sv =====
// Request and result channel interfaces of the day-of-year converter.
`default_nettype none

interface gdoy_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] year;
  logic        [3:0]  month_in;
  logic signed [9:0]  day_value;

  modport source (output valid, func, year, month_in, day_value, input ready);
  modport sink   (input valid, func, year, month_in, day_value, output ready);
endinterface

interface gdoy_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [8:0] year_day;
  logic [3:0] month_out;
  logic [4:0] day_out;

  modport source (output valid, status, year_day, month_out, day_out, input ready);
  modport sink   (input valid, status, year_day, month_out, day_out, output ready);
endinterface

`default_nettype wire

// ===== src/gdoy_datapath.sv =====
// Datapath: request registers, leap-year divider, month walk and result register.
`default_nettype none

module gdoy_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               func_i,
  input  wire logic signed [15:0] year_i,
  input  wire logic        [3:0]  month_in_i,
  input  wire logic signed [9:0]  day_value_i,
  input  wire gdoy_pkg::gdoy_cmd_t cmd_i,
  output gdoy_pkg::gdoy_sts_t     sts_o,
  output logic                    status_o,
  output logic [8:0]              year_day_o,
  output logic [3:0]              month_out_o,
  output logic [4:0]              day_out_o
);
  import gdoy_pkg::*;

  logic               func_q;
  logic [15:0]        year_q;
  logic [3:0]         month_q;
  logic [9:0]         dv_q;
  logic [QuoBits-1:0] quo_q, quo_d;
  logic               leap_q, leap_d;
  logic               bad_q, bad_d;
  logic [8:0]         val_q;
  logic [3:0]         mon_q;
  logic [ProdBits-1:0] prod;
  logic [YearBits-1:0] rem25;
  logic               div4, div16, div25;
  logic               dv_pos, month_ok, date_ok, yday_ok;
  logic [4:0]         chk_len, walk_len;
  logic [8:0]         yday_max;
  logic               status_q;
  logic [8:0]         year_day_q;
  logic [3:0]         month_out_q;
  logic [4:0]         day_out_q;

  // Quotient of the year by 25 through a reciprocal multiplication.
  assign prod  = ProdBits'(year_q[YearBits-1:0]) * ProdBits'(Recip25);
  assign quo_d = prod[ProdBits-1:Recip25Sh];

  // Divisible by 100 means by 4 and 25; divisible by 400 means by 16 and 25.
  always_comb begin
    rem25    = year_q[YearBits-1:0] - YearBits'(quo_q) * Div25;
    div4     = (year_q[1:0] == 2'b00);
    div16    = (year_q[3:0] == 4'b0000);
    div25    = (rem25 == '0);
    leap_d   = div4 && (!div25 || div16);
    dv_pos   = !dv_q[9] && (dv_q != '0);
    month_ok = month_q inside {[4'd1:MonthsPerYr]};
    chk_len  = month_len(leap_d, month_q - 4'd1);
    date_ok  = month_ok && dv_pos && (dv_q[8:0] <= 9'(chk_len));
    yday_max = leap_d ? DaysLeap : DaysCommon;
    yday_ok  = dv_pos && (dv_q[8:0] <= yday_max);
    bad_d    = year_q[15] || ((func_q == FuncYdayToDate) ? !yday_ok : !date_ok);
  end

  // Walk over the months: add lengths of whole months before the given one,
  // or take whole month lengths off the day of year until it fits.
  always_comb begin
    walk_len = month_len(leap_q, mon_q);
    if (func_q == FuncYdayToDate) begin
      sts_o.more = (mon_q < LastMonthIdx) && (val_q > 9'(walk_len));
    end else begin
      sts_o.more = ((5'(mon_q) + 5'd1) < 5'(month_q));
    end
    sts_o.bad = bad_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      year_q  <= year_i;
      month_q <= month_in_i;
      dv_q    <= day_value_i;
    end
    if (cmd_i.divide) begin
      quo_q <= quo_d;
    end
    if (cmd_i.check) begin
      leap_q <= leap_d;
      bad_q  <= bad_d;
      val_q  <= dv_q[8:0];
    end else if (cmd_i.step) begin
      val_q <= (func_q == FuncYdayToDate) ? val_q - 9'(walk_len) : val_q + 9'(walk_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_q <= '0;
    end else if (cmd_i.check) begin
      mon_q <= '0;
    end else if (cmd_i.step) begin
      mon_q <= mon_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q    <= bad_q ? StatusBad : StatusOk;
      year_day_q  <= (!bad_q && func_q == FuncDateToYday) ? val_q : '0;
      month_out_q <= (!bad_q && func_q == FuncYdayToDate) ? mon_q + 4'd1 : '0;
      day_out_q   <= (!bad_q && func_q == FuncYdayToDate) ? val_q[4:0] : '0;
    end
  end

  assign status_o    = status_q;
  assign year_day_o  = year_day_q;
  assign month_out_o = month_out_q;
  assign day_out_o   = day_out_q;

`ifndef SYNTH
  a_mon_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mon_q <= LastMonthIdx)
    else $error("month walk ran past December");

  a_good_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !bad_q) |=> (status_q == StatusOk) &&
      ((func_q == FuncYdayToDate) ? (month_out_q != '0 && day_out_q != '0)
                                  : (year_day_q != '0)))
    else $error("valid result carries a zero field");
`endif

endmodule

`default_nettype wire

// ===== src/gdoy_ctrl.sv =====
// Controller: sequences capture, divide, check, month walk and result load.
`default_nettype none

module gdoy_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  input  wire logic                rsp_ready_i,
  output logic                     rsp_valid_o,
  input  wire gdoy_pkg::gdoy_sts_t sts_i,
  output gdoy_pkg::gdoy_cmd_t      cmd_o
);
  import gdoy_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_CHK   = 5'b00100,
    S_WALK  = 5'b01000,
    S_DONE  = 5'b10000
  } gdoy_state_e;

  gdoy_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.divide = 1'b1;
        state_d      = S_CHK;
      end
      S_CHK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.bad ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (sts_i.more) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == S_DIV))
    else $error("accepted request did not start the divide step");

  a_bad_skips_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK && sts_i.bad) |=> (state_q == S_DONE))
    else $error("invalid request entered the month walk");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (rsp_valid_o && state_q == S_IDLE))
    else $error("loaded result is not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || rsp_ready_i))
    else $error("result register overwritten while still pending");
`endif

endmodule

`default_nettype wire

// ===== src/gregorian_day_of_year_converter_top.sv =====
// Top level of the Gregorian day-of-year converter.
//
// The block takes one request at a time on req_i and returns one result on
// rsp_o for every request. A request with func 0 turns year, month and day
// into the day of the year; func 1 turns year and day of year into month and
// day. Invalid requests return status 1 with all other result fields zero.
// A request passes through the divide and check steps; an invalid one then goes
// straight to the result load, while a valid one first walks the month table
// across k (0 to 11) whole months, one month-table entry visited per cycle.
// The next request is accepted the cycle after the result is loaded.
// The result sits in its own output register: while the receiver stalls it
// holds steady, and the block accepts and works on the next request, only
// waiting at the end of that work until the pending result is taken.
// Reset clears the controller and the output valid flag; no result is
// pending afterward and the block is ready for a request at once.
`default_nettype none

module gregorian_day_of_year_converter_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gdoy_req_if.sink  req_i,
  gdoy_rsp_if.source rsp_o
);
  import gdoy_pkg::*;

  gdoy_cmd_t cmd;
  gdoy_sts_t sts;

  // The controller steps through the work of one request.
  gdoy_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the request, the month walk and the result register.
  gdoy_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (req_i.func),
    .year_i      (req_i.year),
    .month_in_i  (req_i.month_in),
    .day_value_i (req_i.day_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .status_o    (rsp_o.status),
    .year_day_o  (rsp_o.year_day),
    .month_out_o (rsp_o.month_out),
    .day_out_o   (rsp_o.day_out)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench of the Gregorian day-of-year converter.
`timescale 1ns / 100ps

module tb_top;
  import gdoy_pkg::*;

  // One request as the sender offers it.
  typedef struct packed {
    logic               func;
    logic signed [15:0] year;
    logic        [3:0]  month_in;
    logic signed [9:0]  day_value;
  } date_req_t;

  // One result as the receiver takes it.
  typedef struct packed {
    logic       status;
    logic [8:0] year_day;
    logic [3:0] month_out;
    logic [4:0] day_out;
  } date_rsp_t;

  // A row of the directed part. When known is set, the result columns hold
  // the answer typed in by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic               func;
    logic signed [15:0] year;
    logic        [3:0]  month_in;
    logic signed [9:0]  day_value;
    logic               known;
    logic               status;
    logic        [8:0]  year_day;
    logic        [3:0]  month_out;
    logic        [4:0]  day_out;
  } date_row_t;

  localparam int NumDirected = 26;
  localparam int NumRandom   = 875;
  // The last stretch of the random part runs with no idling on either side.
  localparam int CalmItems   = 150;
  // Random item at which the receiver starts its long hold-off.
  localparam int HoldAtItem  = 250;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 20;
  localparam int CycleLimit  = 200000;
  localparam int ReportMax   = 10;

  localparam int CommonMonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam date_row_t DirectedRows [NumDirected] = '{
    // Year zero is accepted and is a leap year.
    '{FuncDateToYday, 16'sd0,     4'd1,  10'sd1,   1'b1, StatusOk,  9'd1,   4'd0,  5'd0},
    '{FuncDateToYday, 16'sd0,     4'd2,  10'sd29,  1'b1, StatusOk,  9'd60,  4'd0,  5'd0},
    // Year ends in a leap year divisible by 400 and a century common year.
    '{FuncDateToYday, 16'sd2000,  4'd12, 10'sd31,  1'b1, StatusOk,  9'd366, 4'd0,  5'd0},
    '{FuncDateToYday, 16'sd1900,  4'd12, 10'sd31,  1'b1, StatusOk,  9'd365, 4'd0,  5'd0},
    '{FuncDateToYday, 16'sd1900,  4'd2,  10'sd29,  1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncDateToYday, 16'sd2024,  4'd2,  10'sd29,  1'b1, StatusOk,  9'd60,  4'd0,  5'd0},
    '{FuncDateToYday, 16'sd32767, 4'd12, 10'sd31,  1'b1, StatusOk,  9'd365, 4'd0,  5'd0},
    // Negative years are rejected in both directions.
    '{FuncDateToYday, -16'sd1,    4'd1,  10'sd1,   1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncYdayToDate, 16'sh8000,  4'd0,  10'sd1,   1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    // Month outside 1..12.
    '{FuncDateToYday, 16'sd2023,  4'd0,  10'sd1,   1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncDateToYday, 16'sd2023,  4'd13, 10'sd1,   1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncDateToYday, 16'sd2023,  4'd15, 10'sd10,  1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    // Day of month below 1 or past the month's end.
    '{FuncDateToYday, 16'sd2023,  4'd4,  10'sd31,  1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncDateToYday, 16'sd2023,  4'd3,  10'sd0,   1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncDateToYday, 16'sd2023,  4'd1,  10'sh200, 1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncDateToYday, 16'sd2023,  4'd1,  10'sd511, 1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncDateToYday, 16'sd2023,  4'd7,  10'sd4,   1'b0, StatusOk,  9'd0,   4'd0,  5'd0},
    // Day of year zero, past the year's end, or negative.
    '{FuncYdayToDate, 16'sd2023,  4'd0,  10'sd0,   1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncYdayToDate, 16'sd2023,  4'd0,  10'sd366, 1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncYdayToDate, 16'sd2024,  4'd0,  10'sd366, 1'b1, StatusOk,  9'd0,   4'd12, 5'd31},
    '{FuncYdayToDate, 16'sd2023,  4'd0,  10'sd1,   1'b1, StatusOk,  9'd0,   4'd1,  5'd1},
    // The month field is ignored when converting a day of year.
    '{FuncYdayToDate, 16'sd2024,  4'd15, 10'sd60,  1'b1, StatusOk,  9'd0,   4'd2,  5'd29},
    '{FuncYdayToDate, 16'sd2023,  4'd0,  10'sd60,  1'b1, StatusOk,  9'd0,   4'd3,  5'd1},
    '{FuncYdayToDate, 16'sd2023,  4'd0,  -10'sd1,  1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncYdayToDate, 16'sd2000,  4'd0,  10'sd511, 1'b1, StatusBad, 9'd0,   4'd0,  5'd0},
    '{FuncYdayToDate, 16'sd1900,  4'd9,  10'sd200, 1'b0, StatusOk,  9'd0,   4'd0,  5'd0}
  };

  logic clk_i;
  logic rst_ni;

  gdoy_req_if req_bus ();
  gdoy_rsp_if rsp_bus ();

  gregorian_day_of_year_converter_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Results still owed by the block, oldest first.
  date_rsp_t pending_conversions [$];
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  // Set by the sender to ask the receiver for one long hold-off.
  bit        hold_request = 1'b0;
  // Set near the end of the run: both sides stop idling.
  bit        calm_tail = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the result the block owes for a request. Years are checked
  // first, then the leap rule picks February's length, and the month table
  // is walked forward (date to day of year) or peeled off (day of year to date).
  function automatic date_rsp_t convert_date(date_req_t r);
    date_rsp_t res;
    int        yr;
    int        dv;
    int        mon;
    int        acc;
    bit        leap;
    int        lens [12];
    res = '0;
    res.status = StatusBad;
    yr = $signed(r.year);
    dv = $signed(r.day_value);
    if (yr < 0) begin
      return res;
    end
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    lens = CommonMonthDays;
    if (leap) begin
      lens[1] = 29;
    end
    if (r.func == FuncDateToYday) begin
      mon = int'(r.month_in);
      if (mon >= 1 && mon <= 12) begin
        if (dv >= 1 && dv <= lens[mon-1]) begin
          acc = dv;
          for (int m = 0; m < mon - 1; m++) begin
            acc += lens[m];
          end
          res.status = StatusOk;
          res.year_day = 9'(acc);
        end
      end
    end else begin
      if (dv >= 1 && dv <= (leap ? 366 : 365)) begin
        acc = dv;
        mon = 0;
        while (mon < 11 && acc > lens[mon]) begin
          acc -= lens[mon];
          mon++;
        end
        res.status = StatusOk;
        res.month_out = 4'(mon + 1);
        res.day_out = 5'(acc);
      end
    end
    return res;
  endfunction

  // Most random requests are plausible dates with random content, leaning on
  // century and leap years and on the edges of each month and year. The rest
  // are raw noise over the full width of every field.
  function automatic date_req_t random_request();
    date_req_t r;
    int        yr;
    int        lim;
    int        mon;
    bit        leap;
    r.func = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 15) begin
      r.year = 16'($urandom);
      r.month_in = 4'($urandom);
      r.day_value = 10'($urandom);
      return r;
    end
    case ($urandom_range(0, 3))
      0: yr = int'($urandom_range(0, 32767));
      1: yr = 100 * int'($urandom_range(0, 327));
      2: yr = 4 * int'($urandom_range(0, 8191));
      default: yr = int'($urandom_range(1890, 2110));
    endcase
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    r.year = 16'(yr);
    if (r.func == FuncDateToYday) begin
      mon = int'($urandom_range(1, 12));
      lim = CommonMonthDays[mon-1] + ((leap && mon == 2) ? 1 : 0);
      r.month_in = 4'(mon);
    end else begin
      lim = leap ? 366 : 365;
      r.month_in = 4'($urandom);
    end
    case ($urandom_range(0, 9))
      0: r.day_value = 10'(lim + 1);
      1: r.day_value = 10'sd0;
      2: r.day_value = 10'(lim);
      default: r.day_value = 10'($urandom_range(1, lim));
    endcase
    return r;
  endfunction

  // Offers one request and returns at the edge where it is taken. The
  // handshake is sampled on the falling edge, where every signal is settled,
  // so the decision never races the block's own update at the rising edge.
  task automatic offer_request(date_req_t r, bit known, date_rsp_t typed_rsp);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.func      <= r.func;
    req_bus.year      <= r.year;
    req_bus.month_in  <= r.month_in;
    req_bus.day_value <= r.day_value;
    do @(negedge clk_i); while (req_bus.ready !== 1'b1);
    @(posedge clk_i);
    pending_conversions.push_back(known ? typed_rsp : convert_date(r));
  endtask

  task automatic check_result();
    date_rsp_t got;
    date_rsp_t want;
    got.status    = rsp_bus.status;
    got.year_day  = rsp_bus.year_day;
    got.month_out = rsp_bus.month_out;
    got.day_out   = rsp_bus.day_out;
    if (pending_conversions.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= ReportMax) begin
        $display("%0t: result with no request outstanding: status %0d yday %0d month %0d day %0d",
                 $realtime, got.status, got.year_day, got.month_out, got.day_out);
      end
      return;
    end
    want = pending_conversions.pop_front();
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= ReportMax) begin
        $display("%0t: expected status %0d yday %0d month %0d day %0d, got %0d %0d %0d %0d",
                 $realtime, want.status, want.year_day, want.month_out, want.day_out,
                 got.status, got.year_day, got.month_out, got.day_out);
      end
    end
  endtask

  // A result is taken at the next rising edge when valid and ready are both
  // high on the falling edge before it; the payload is steady by then.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      check_result();
    end
  end

  // Watchdog on a runaway or hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver. It alternates stretches of readiness with short stalls, and
  // once, on request, stalls long enough for the block to hold a finished
  // result and a second request in progress, which pushes back on the sender.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request && !hold_done && !calm_tail) begin
        hold_done = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Sender and end of run.
  initial begin
    date_req_t req;
    rst_ni            <= 1'b0;
    req_bus.valid     <= 1'b0;
    req_bus.func      <= FuncDateToYday;
    req_bus.year      <= '0;
    req_bus.month_in  <= '0;
    req_bus.day_value <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, both operations and every rejection rule.
    for (int i = 0; i < NumDirected; i++) begin
      req.func      = DirectedRows[i].func;
      req.year      = DirectedRows[i].year;
      req.month_in  = DirectedRows[i].month_in;
      req.day_value = DirectedRows[i].day_value;
      offer_request(req, DirectedRows[i].known,
                    {DirectedRows[i].status, DirectedRows[i].year_day,
                     DirectedRows[i].month_out, DirectedRows[i].day_out});
    end

    // Random part, checked against the predictor only.
    for (int i = 0; i < NumRandom; i++) begin
      if (i == HoldAtItem) begin
        hold_request = 1'b1;
      end
      if (i == NumRandom - CalmItems) begin
        calm_tail = 1'b1;
      end
      offer_request(random_request(), 1'b0, '0);
    end
    req_bus.valid <= 1'b0;

    while (pending_conversions.size() != 0) @(posedge clk_i);
    // Wait out the drain time to catch any stray result after the last one.
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_conversions.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/gdoy_pkg.sv
src/gdoy_if.sv
src/gdoy_datapath.sv
src/gdoy_ctrl.sv
src/gregorian_day_of_year_converter_top.sv
sim/tb_top.sv
